// ===== rtl/dvru_pkg.sv =====
package dvru_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_FETCH  = 5'b00100,
        S_DECIDE = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_UNCHANGED = 3'd2,
        ST_LOOP      = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_OWN_ADDR_0      = 3'd0;
    localparam logic [2:0] CFG_OWN_ADDR_1      = 3'd1;
    localparam logic [2:0] CFG_OWN_ADDR_2      = 3'd2;
    localparam logic [2:0] CFG_OWN_ADDR_3      = 3'd3;
    localparam logic [2:0] CFG_OWN_ADDR_ENABLE = 3'd4;

    localparam int CFG_INDEX_BITS = 3;
    localparam int OWN_ADDR_SLOTS = 4;

endpackage

// ===== rtl/distance_vector_route_update.sv =====
// Distance-vector route table engine. Each request carries one advertised
// route (func 0) or one local route to install (func 1). The engine scans
// its destination memory one slot per cycle through a single read port,
// comparing each stored destination against the request, and then reads,
// updates or appends the matching entry. A request passes through the search,
// fetch (only when the destination is found), decide and out states; a
// finished result waits in the out state while the output register stalls.
// in_stall stays high from acceptance until the result has been handed to
// the output register; the output register lets the next request start while
// the previous result still waits. The table holds no valid bits and needs
// no clearing after reset: only slots below the route count are ever
// compared or fetched. The user must write own interface addresses through
// the cfg port only while idle; the block itself does not enforce this.
// cfg_ready is always high.
module distance_vector_route_update #(
    parameter int TABLE_DEPTH   = 64,
    parameter int COST_BITS     = 8,
    parameter int NUM_OWN_ADDRS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dvru_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]                         cfg_data,

    // Request channel.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic [31:0]                         adv_dest,
    input  logic [7:0]                          adv_cost,
    input  logic [31:0]                         adv_next_hop,
    input  logic [31:0]                         sender_addr,
    input  logic [31:0]                         recv_iface,

    // Result channel.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          status,
    output logic [5:0]                          entry_index,
    output logic [7:0]                          entry_cost,
    output logic [31:0]                         entry_next_hop
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [COST_BITS-1:0] COST_MAX = '1;
    localparam logic [CW-1:0] COUNT_FULL = CW'(TABLE_DEPTH);

    // Route table memories.
    logic [31:0]          dest_mem [TABLE_DEPTH];
    logic [31:0]          nh_mem   [TABLE_DEPTH];
    logic [31:0]          iface_mem[TABLE_DEPTH];
    logic [COST_BITS-1:0] cost_mem [TABLE_DEPTH];

    // Configuration registers.
    logic [31:0] own_addr_reg [dvru_pkg::OWN_ADDR_SLOTS];
    logic [3:0]  own_addr_enable_reg;

    // Sequencer and scan state.
    dvru_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    scan_reg, scan_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]    cmp_slot_reg, cmp_slot_next;
    logic [AW-1:0]    slot_reg, slot_next;
    logic             found_reg, found_next;

    // Latched request.
    logic        func_reg;
    logic [31:0] dest_reg;
    logic [7:0]  cost_reg;
    logic [31:0] nh_reg;
    logic [31:0] sender_reg;
    logic [31:0] iface_reg;

    // Registered memory read data.
    logic [31:0]          dest_rd_reg;
    logic [31:0]          nh_rd_reg;
    logic [COST_BITS-1:0] cost_rd_reg;

    // Pending result and output register.
    dvru_pkg::status_t    res_status_reg;
    logic [AW-1:0]        res_slot_reg;
    logic [COST_BITS-1:0] res_cost_reg;
    logic [31:0]          res_nh_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           status_reg;
    logic [5:0]           entry_index_reg;
    logic [7:0]           entry_cost_reg;
    logic [31:0]          entry_next_hop_reg;

    // Decision signals.
    logic                 hit;
    logic                 own_match;
    logic [16:0]          cost_sum;
    logic [COST_BITS-1:0] new_cost;
    logic [31:0]          new_nh;
    logic                 do_write;
    logic [AW-1:0]        write_slot;
    dvru_pkg::status_t    decide_status;
    logic [COST_BITS-1:0] decide_cost;
    logic [31:0]          decide_nh;
    logic                 out_free;
    logic [31:0]          slot_ext;
    logic [31:0]          cost_ext;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != dvru_pkg::S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dvru_pkg::OWN_ADDR_SLOTS; i++)
            begin
                own_addr_reg[i] <= '0;
            end
            own_addr_enable_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index) inside
                dvru_pkg::CFG_OWN_ADDR_0, dvru_pkg::CFG_OWN_ADDR_1,
                dvru_pkg::CFG_OWN_ADDR_2, dvru_pkg::CFG_OWN_ADDR_3:
                begin
                    own_addr_reg[cfg_index[1:0]] <= cfg_data;
                end
                dvru_pkg::CFG_OWN_ADDR_ENABLE:
                begin
                    own_addr_enable_reg <= cfg_data[3:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // A stored destination from the previous read equals the request.
    assign hit = cmp_valid_reg && (dest_rd_reg == dest_reg);

    // Loop guard against the enabled own addresses.
    always_comb
    begin
        own_match = 1'b0;
        for (int i = 0; i < NUM_OWN_ADDRS; i++)
        begin
            if (own_addr_enable_reg[i] && (own_addr_reg[i] == nh_reg))
            begin
                own_match = 1'b1;
            end
        end
    end

    // New cost and next hop, saturated at the maximum cost.
    always_comb
    begin
        cost_sum = 17'(cost_reg) + (func_reg ? 17'd0 : 17'd1);
        new_cost = (cost_sum > 17'(COST_MAX)) ? COST_MAX : cost_sum[COST_BITS-1:0];
        new_nh   = func_reg ? nh_reg : sender_reg;
    end

    // Outcome of the request once the search and entry read are done.
    always_comb
    begin
        do_write      = 1'b0;
        write_slot    = slot_reg;
        decide_status = dvru_pkg::ST_UPDATED;
        decide_cost   = new_cost;
        decide_nh     = new_nh;
        if (!found_reg)
        begin
            write_slot = count_reg[AW-1:0];
            if (count_reg == COUNT_FULL)
            begin
                decide_status = dvru_pkg::ST_FULL;
                decide_cost   = '0;
                decide_nh     = '0;
            end
            else
            begin
                do_write      = 1'b1;
                decide_status = dvru_pkg::ST_INSERTED;
            end
        end
        else if (func_reg)
        begin
            do_write = 1'b1;
        end
        else if (new_cost >= cost_rd_reg)
        begin
            decide_status = dvru_pkg::ST_UNCHANGED;
            decide_cost   = cost_rd_reg;
            decide_nh     = nh_rd_reg;
        end
        else if (own_match)
        begin
            decide_status = dvru_pkg::ST_LOOP;
            decide_cost   = cost_rd_reg;
            decide_nh     = nh_rd_reg;
        end
        else
        begin
            do_write = 1'b1;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_slot_next  = cmp_slot_reg;
        slot_next      = slot_reg;
        found_next     = found_reg;
        unique case (state_reg)
            dvru_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next     = dvru_pkg::S_SEARCH;
                    scan_next      = '0;
                    cmp_valid_next = 1'b0;
                    found_next     = 1'b0;
                end
            end
            dvru_pkg::S_SEARCH:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    slot_next  = cmp_slot_reg;
                    state_next = dvru_pkg::S_FETCH;
                end
                else if (scan_reg == count_reg)
                begin
                    found_next     = 1'b0;
                    cmp_valid_next = 1'b0;
                    state_next     = dvru_pkg::S_DECIDE;
                end
                else
                begin
                    scan_next      = scan_reg + CW'(1);
                    cmp_valid_next = 1'b1;
                    cmp_slot_next  = scan_reg[AW-1:0];
                end
            end
            dvru_pkg::S_FETCH:
            begin
                state_next = dvru_pkg::S_DECIDE;
            end
            dvru_pkg::S_DECIDE:
            begin
                slot_next = write_slot;
                if (!found_reg && do_write)
                begin
                    count_next = count_reg + CW'(1);
                end
                state_next = dvru_pkg::S_OUT;
            end
            dvru_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    state_next = dvru_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dvru_pkg::S_IDLE;
            end
        endcase
    end

    // Output valid handling.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == dvru_pkg::S_OUT) && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dvru_pkg::S_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_slot_reg  <= '0;
            slot_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_slot_reg  <= cmp_slot_next;
            slot_reg      <= slot_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if ((state_reg == dvru_pkg::S_IDLE) && in_valid)
        begin
            func_reg   <= func;
            dest_reg   <= adv_dest;
            cost_reg   <= adv_cost;
            nh_reg     <= adv_next_hop;
            sender_reg <= sender_addr;
            iface_reg  <= recv_iface;
        end
    end

    // Destination memory: one read per scan cycle, and a write on insert.
    always_ff @(posedge clk)
    begin
        if (state_reg == dvru_pkg::S_SEARCH)
        begin
            dest_rd_reg <= dest_mem[scan_reg[AW-1:0]];
        end
        if ((state_reg == dvru_pkg::S_DECIDE) && do_write && !found_reg)
        begin
            dest_mem[write_slot] <= dest_reg;
        end
    end

    // Entry memories: read the matched slot, write the updated or inserted entry.
    always_ff @(posedge clk)
    begin
        if (state_reg == dvru_pkg::S_FETCH)
        begin
            cost_rd_reg <= cost_mem[slot_reg];
            nh_rd_reg   <= nh_mem[slot_reg];
        end
        if ((state_reg == dvru_pkg::S_DECIDE) && do_write)
        begin
            cost_mem[write_slot]  <= new_cost;
            nh_mem[write_slot]    <= new_nh;
            iface_mem[write_slot] <= iface_reg;
        end
    end

    // Pending result.
    always_ff @(posedge clk)
    begin
        if (state_reg == dvru_pkg::S_DECIDE)
        begin
            res_status_reg <= decide_status;
            res_slot_reg   <= (decide_status == dvru_pkg::ST_FULL) ? '0 : write_slot;
            res_cost_reg   <= decide_cost;
            res_nh_reg     <= decide_nh;
        end
    end

    // Result fields zero-extended to 32 bits before narrowing to the port widths.
    assign slot_ext = 32'(res_slot_reg);
    assign cost_ext = 32'(res_cost_reg);

    // Output register.
    always_ff @(posedge clk)
    begin
        if ((state_reg == dvru_pkg::S_OUT) && out_free)
        begin
            status_reg         <= res_status_reg;
            entry_index_reg    <= slot_ext[5:0];
            entry_cost_reg     <= cost_ext[7:0];
            entry_next_hop_reg <= res_nh_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign entry_index    = entry_index_reg;
    assign entry_cost     = entry_cost_reg;
    assign entry_next_hop = entry_next_hop_reg;

    // The route count never exceeds the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_FULL)
        else $error("route count beyond table depth");

    // A pending compare always refers to an occupied slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> (CW'(cmp_slot_reg) < count_reg))
        else $error("compare of an unoccupied slot");

    // The route count only moves on an insert decision.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ($past(state_reg) == dvru_pkg::S_DECIDE) && !$past(found_reg))
        else $error("route count changed outside an insert");

    // A full-table result carries zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == dvru_pkg::ST_FULL)) |->
            (entry_index_reg == '0) && (entry_cost_reg == '0) && (entry_next_hop_reg == '0))
        else $error("table full result with nonzero fields");

endmodule
